### design/pbc_pkg.sv
// shared constants, types and the saturation helper for the point/box collision block
// no dependencies; imported by the channel interfaces and the top level
package pbc_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int SURFACE_GAP   = 7;
  localparam int HALF_BITS     = 31;
  localparam int FRIC_BITS     = 17;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam int D_BITS    = COORD_BITS + 1;
  localparam int PEN_BITS  = COORD_BITS + 2;
  localparam int TGT_BITS  = COORD_BITS + 2;
  localparam int DIFF_BITS = COORD_BITS + 3;
  localparam int PROD_BITS = DIFF_BITS + FRIC_BITS + 1;
  localparam int M_BITS    = PROD_BITS - FRAC_BITS;
  localparam int RES_BITS  = M_BITS + 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_X   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_Y   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_Z   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRICTION = 3'd6;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;
  localparam logic [1:0] AXIS_Z    = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [HALF_BITS-1:0]         half_t;
  typedef logic [FRIC_BITS-1:0]         fric_t;
  typedef logic [1:0]                   axis_t;
  typedef logic signed [D_BITS-1:0]     dist_t;
  typedef logic signed [PEN_BITS-1:0]   pen_t;
  typedef logic signed [TGT_BITS-1:0]   tgt_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [M_BITS-1:0]     mov_t;
  typedef logic signed [RES_BITS-1:0]   res_t;

  localparam fric_t  FRIC_ONE   = FRIC_BITS'(64'd1 << FRAC_BITS);
  localparam half_t  HALF_RESET = HALF_BITS'(64'd1 << FRAC_BITS);
  localparam prod_t  ROUND_HALF = PROD_BITS'(64'd1 << (FRAC_BITS - 1));
  localparam coord_t COORD_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};

  function automatic coord_t sat_coord(input res_t v);
    coord_t r;
    if (v > res_t'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < res_t'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

endpackage

### design/pbc_in_if.sv
// input channel: current and previous point positions with valid/ready
// depends on pbc_pkg
interface pbc_in_if;
  import pbc_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  coord_t prev_x;
  coord_t prev_y;
  coord_t prev_z;

  modport source(output valid, pos_x, pos_y, pos_z, prev_x, prev_y, prev_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, prev_x, prev_y, prev_z, output ready);
endinterface

### design/pbc_out_if.sv
// result channel: corrected position, hit flag and push axis with valid/ready
// depends on pbc_pkg
interface pbc_out_if;
  import pbc_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   hit;
  axis_t  push_axis;

  modport source(output valid, out_x, out_y, out_z, hit, push_axis, input ready);
  modport sink(input valid, out_x, out_y, out_z, hit, push_axis, output ready);
endinterface

### design/point_box_collision_response.sv
// point versus axis-aligned box collision response, four-stage pipeline
// depends on pbc_pkg, pbc_in_if and pbc_out_if
//
// Usage: points arrive on in_ch (current and previous position, Q16.16) and
// corrected positions leave on out_ch together with hit and push_axis. The
// box center, half extents and friction are set through the cfg_we/cfg_addr/
// cfg_data write port. The user must write them only while no point is in
// flight; the block does not enforce this and the pipeline reads them directly.
// A point passes through the stage 1, 2, 3 and 4 registers in order, and
// out_ch.valid is the stage 4 valid bit. One point is accepted every cycle
// while out_ch does not stall; stage 3 holds one 35 x 18 multiplier per axis
// and each stage carries its own valid bit.
// Each stage moves forward when it is empty or the next stage moves, so a
// stall on out_ch fills the pipeline and then drops in_ch.ready; nothing is
// lost or repeated, and bubbles are squeezed out.
// Reset (rst_n low, synchronous) empties the pipeline and loads center 0,
// half extents 1.0 and friction 0.
module point_box_collision_response (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pbc_pkg::CFG_IDX_BITS-1:0] cfg_addr,
  input  logic [pbc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  pbc_in_if.sink                           in_ch,
  pbc_out_if.source                        out_ch
);
  import pbc_pkg::*;

  // configuration
  coord_t ctr_r [3];
  half_t  half_r[3];
  fric_t  fric_r;
  fric_t  fric_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        ctr_r[i]  <= '0;
        half_r[i] <= HALF_RESET;
      end
      fric_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CENTER_X: ctr_r[0]  <= coord_t'(cfg_data);
        CFG_CENTER_Y: ctr_r[1]  <= coord_t'(cfg_data);
        CFG_CENTER_Z: ctr_r[2]  <= coord_t'(cfg_data);
        CFG_HALF_X:   half_r[0] <= cfg_data[HALF_BITS-1:0];
        CFG_HALF_Y:   half_r[1] <= cfg_data[HALF_BITS-1:0];
        CFG_HALF_Z:   half_r[2] <= cfg_data[HALF_BITS-1:0];
        CFG_FRICTION: fric_r    <= cfg_data[FRIC_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign fric_sat = (fric_r > FRIC_ONE) ? FRIC_ONE : fric_r;

  // stage handshake
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: offsets, inside test, penetration depths
  coord_t pos_in[3];
  coord_t prev_in[3];
  pen_t   pen_nxt[3];
  logic   dpos_nxt[3];
  logic   inside_nxt;

  assign pos_in[0]  = in_ch.pos_x;
  assign pos_in[1]  = in_ch.pos_y;
  assign pos_in[2]  = in_ch.pos_z;
  assign prev_in[0] = in_ch.prev_x;
  assign prev_in[1] = in_ch.prev_y;
  assign prev_in[2] = in_ch.prev_z;

  always_comb begin
    dist_t             d;
    logic [D_BITS-1:0] absd;
    inside_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d    = dist_t'(pos_in[i]) - dist_t'(ctr_r[i]);
      absd = d[D_BITS-1] ? D_BITS'(-d) : D_BITS'(d);
      if (!(absd < {{(D_BITS-HALF_BITS){1'b0}}, half_r[i]})) inside_nxt = 1'b0;
      pen_nxt[i]  = $signed({{(PEN_BITS-HALF_BITS){1'b0}}, half_r[i]})
                  - $signed({{(PEN_BITS-D_BITS){1'b0}}, absd});
      dpos_nxt[i] = !d[D_BITS-1] && (d != '0);
    end
  end

  coord_t pos1_r [3];
  coord_t prev1_r[3];
  pen_t   pen1_r [3];
  logic   dpos1_r[3];
  logic   inside1_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      for (int i = 0; i < 3; i++) begin
        pos1_r[i]  <= pos_in[i];
        prev1_r[i] <= prev_in[i];
        pen1_r[i]  <= pen_nxt[i];
        dpos1_r[i] <= dpos_nxt[i];
      end
      inside1_r <= inside_nxt;
    end
  end

  // stage 2: push axis and target position
  axis_t axis_nxt;
  tgt_t  tgt_nxt[3];

  always_comb begin
    tgt_t reach;
    if (!inside1_r) begin
      axis_nxt = AXIS_NONE;
    end else if (pen1_r[0] <= pen1_r[1] && pen1_r[0] <= pen1_r[2]) begin
      axis_nxt = AXIS_X;
    end else if (pen1_r[1] <= pen1_r[0] && pen1_r[1] <= pen1_r[2]) begin
      axis_nxt = AXIS_Y;
    end else begin
      axis_nxt = AXIS_Z;
    end
    for (int i = 0; i < 3; i++) begin
      reach      = tgt_t'({1'b0, half_r[i]}) + tgt_t'(SURFACE_GAP);
      tgt_nxt[i] = tgt_t'(pos1_r[i]);
      if (axis_nxt == 2'(i + 1)) begin
        tgt_nxt[i] = dpos1_r[i] ? tgt_t'(ctr_r[i]) + reach : tgt_t'(ctr_r[i]) - reach;
      end
    end
  end

  tgt_t   tgt2_r [3];
  coord_t prev2_r[3];
  axis_t  axis2_r;
  logic   hit2_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      for (int i = 0; i < 3; i++) begin
        tgt2_r[i]  <= tgt_nxt[i];
        prev2_r[i] <= prev1_r[i];
      end
      axis2_r <= axis_nxt;
      hit2_r  <= inside1_r;
    end
  end

  // stage 3: blend product
  prod_t prod_nxt[3];

  always_comb begin
    diff_t               c;
    logic signed [FRIC_BITS:0] f;
    f = $signed({1'b0, fric_sat});
    for (int i = 0; i < 3; i++) begin
      c           = diff_t'(tgt2_r[i]) - diff_t'(prev2_r[i]);
      prod_nxt[i] = prod_t'(c) * prod_t'(f);
    end
  end

  prod_t prod3_r[3];
  tgt_t  tgt3_r [3];
  axis_t axis3_r;
  logic  hit3_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      for (int i = 0; i < 3; i++) begin
        prod3_r[i] <= prod_nxt[i];
        tgt3_r[i]  <= tgt2_r[i];
      end
      axis3_r <= axis2_r;
      hit3_r  <= hit2_r;
    end
  end

  // stage 4: on a hit round, subtract and saturate, else pass the target; into the output register
  coord_t res_nxt[3];

  always_comb begin
    prod_t sum;
    mov_t  m;
    res_t  r;
    for (int i = 0; i < 3; i++) begin
      sum = prod3_r[i] + ROUND_HALF;
      m   = mov_t'(sum >>> FRAC_BITS);
      r   = res_t'(tgt3_r[i]) - res_t'(m);
      res_nxt[i] = hit3_r ? sat_coord(r) : coord_t'(tgt3_r[i]);
    end
  end

  coord_t res4_r[3];
  axis_t  axis4_r;
  logic   hit4_r;

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      for (int i = 0; i < 3; i++) begin
        res4_r[i] <= res_nxt[i];
      end
      axis4_r <= axis3_r;
      hit4_r  <= hit3_r;
    end
  end

  assign out_ch.valid     = v4_r;
  assign out_ch.out_x     = res4_r[0];
  assign out_ch.out_y     = res4_r[1];
  assign out_ch.out_z     = res4_r[2];
  assign out_ch.hit       = hit4_r;
  assign out_ch.push_axis = axis4_r;

  // checks
  a_hit_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hit == (out_ch.push_axis != AXIS_NONE)))
    else $error("hit flag and push axis disagree");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output back pressure");

  a_axis_min: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && axis_nxt == AXIS_X) |-> (pen1_r[0] <= pen1_r[1] && pen1_r[0] <= pen1_r[2]))
    else $error("x chosen without least penetration");

  a_axis_z_min: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && axis_nxt == AXIS_Z) |-> (pen1_r[2] < pen1_r[0] && pen1_r[2] < pen1_r[1]))
    else $error("z chosen without strictly least penetration");

endmodule
